>>> rtl/u8d_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_pkg
// types and constants shared by the utf-8 stream decoder
// ----------------------------------------------------------------------------
package u8d_pkg;

  typedef enum logic [1:0] {
    MODE_START  = 2'd0,
    MODE_FOLLOW = 2'd1,
    MODE_RESYNC = 2'd2
  } u8d_mode_e;

  typedef enum logic [2:0] {
    ST_CONSUMED  = 3'd0,
    ST_CODEPOINT = 3'd1,
    ST_BADLEAD   = 3'd2,
    ST_BADCONT   = 3'd3,
    ST_RANGE     = 3'd4,
    ST_TRUNC     = 3'd5
  } u8d_status_e;

  localparam logic REQ_DATA   = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  localparam int unsigned CP_W  = 21;
  localparam int unsigned ACC_W = 31;

  localparam logic [CP_W-1:0] MAX_CODE_POINT = 21'h10FFFF;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
  } u8d_in_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic [2:0]      status;
  } u8d_out_t;

  typedef struct packed {
    u8d_mode_e        mode;
    logic [ACC_W-1:0] acc;
    logic [2:0]       seen;
    logic [2:0]       len;
  } u8d_state_t;

  localparam u8d_state_t STATE_RESET = '{
    mode: MODE_START,
    acc:  '0,
    seen: 3'd0,
    len:  3'd1
  };

endpackage
`default_nettype wire

>>> rtl/u8d_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_step
// decode of one beat: next decoder state and the result beat
// ----------------------------------------------------------------------------
module u8d_step
  import u8d_pkg::*;
(
  input  wire u8d_state_t state_i,
  input  wire u8d_in_t    item_i,
  output u8d_state_t      state_o,
  output u8d_out_t        result_o
);

  logic             is_cont;
  logic [7:0]       b;
  logic [ACC_W-1:0] acc_shift;
  logic [2:0]       seen_inc;
  u8d_state_t       lead_state;
  u8d_status_e      lead_st;
  logic [CP_W-1:0]  lead_cp;
  u8d_status_e      st;
  logic [CP_W-1:0]  cp;

  assign b         = item_i.data_byte;
  assign is_cont   = (b[7:6] == 2'b10);
  assign acc_shift = {state_i.acc[ACC_W-7:0], b[5:0]};
  assign seen_inc  = state_i.seen + 3'd1;

  // byte decoded as the start of a sequence
  always_comb begin
    lead_state      = state_i;
    lead_state.mode = MODE_START;
    lead_st         = ST_CONSUMED;
    lead_cp         = '0;
    unique case (b) inside
      [8'h00:8'h7F]: begin
        lead_st = ST_CODEPOINT;
        lead_cp = {{(CP_W-8){1'b0}}, b};
      end
      [8'hC0:8'hDF]: begin
        lead_state = '{mode: MODE_FOLLOW, acc: {{(ACC_W-5){1'b0}}, b[4:0]},
                       seen: 3'd1, len: 3'd2};
      end
      [8'hE0:8'hEF]: begin
        lead_state = '{mode: MODE_FOLLOW, acc: {{(ACC_W-4){1'b0}}, b[3:0]},
                       seen: 3'd1, len: 3'd3};
      end
      [8'hF0:8'hF7]: begin
        lead_state = '{mode: MODE_FOLLOW, acc: {{(ACC_W-3){1'b0}}, b[2:0]},
                       seen: 3'd1, len: 3'd4};
      end
      [8'hF8:8'hFB]: begin
        lead_state = '{mode: MODE_FOLLOW, acc: {{(ACC_W-2){1'b0}}, b[1:0]},
                       seen: 3'd1, len: 3'd5};
      end
      [8'hFC:8'hFD]: begin
        lead_state = '{mode: MODE_FOLLOW, acc: {{(ACC_W-1){1'b0}}, b[0]},
                       seen: 3'd1, len: 3'd6};
      end
      default: begin
        // stray continuation byte or 0xfe / 0xff
        lead_state.mode = MODE_RESYNC;
        lead_st         = ST_BADLEAD;
      end
    endcase
  end

  always_comb begin
    state_o = state_i;
    st      = ST_CONSUMED;
    cp      = '0;
    if (item_i.req_type == REQ_FINISH) begin
      st      = (state_i.mode == MODE_FOLLOW) ? ST_TRUNC : ST_CONSUMED;
      state_o = STATE_RESET;
    end else begin
      unique case (state_i.mode)
        MODE_FOLLOW: begin
          if (!is_cont) begin
            state_o.mode = MODE_RESYNC;
            st           = ST_BADCONT;
          end else begin
            state_o.acc  = acc_shift;
            state_o.seen = seen_inc;
            if (seen_inc == state_i.len) begin
              state_o.mode = MODE_START;
              if (acc_shift > {{(ACC_W-CP_W){1'b0}}, MAX_CODE_POINT}) begin
                st = ST_RANGE;
              end else begin
                st = ST_CODEPOINT;
                cp = acc_shift[CP_W-1:0];
              end
            end
          end
        end
        MODE_RESYNC: begin
          if (!is_cont) begin
            state_o = lead_state;
            st      = lead_st;
            cp      = lead_cp;
          end
        end
        default: begin
          state_o = lead_state;
          st      = lead_st;
          cp      = lead_cp;
        end
      endcase
    end
  end

  assign result_o.code_point = cp;
  assign result_o.status     = st;

endmodule
`default_nettype wire

>>> rtl/utf8_stream_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// byte-serial utf-8 decoder, one result beat for every input beat
// ----------------------------------------------------------------------------
// path: a beat accepted into the input register moves on through the result
//   register to the result port, where it is held until it is taken
// throughput: one beat per cycle while the result side does not stall
// reset: rst_ni low clears both valid flags and puts the decoder in start mode
//   with an empty accumulator; payload registers are not reset
// ----------------------------------------------------------------------------
module utf8_stream_decoder
  import u8d_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          in_valid_i,
  output logic         in_stall_o,
  input  wire u8d_in_t in_data_i,
  output logic         out_valid_o,
  input  wire          out_stall_i,
  output u8d_out_t     out_data_o
);

  // input register
  u8d_in_t    in_q;
  logic       in_vld_d, in_vld_q;
  // decoder state
  u8d_state_t state_d, state_q;
  // result register
  u8d_out_t   out_d, out_q;
  logic       out_vld_d, out_vld_q;

  logic in_take;
  logic adv;

  // the held beat moves on whenever the result register is empty or is
  // being taken in this cycle
  assign adv        = in_vld_q & (~out_vld_q | ~out_stall_i);
  // only a held beat that cannot move stalls the input
  assign in_stall_o = in_vld_q & ~adv;
  assign in_take    = in_valid_i & ~in_stall_o;

  assign in_vld_d  = in_take | (in_vld_q & ~adv);
  assign out_vld_d = adv | (out_vld_q & out_stall_i);

  u8d_step u_step (
    .state_i  (state_q),
    .item_i   (in_q),
    .state_o  (state_d),
    .result_o (out_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= STATE_RESET;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      // decoder state only moves with a beat going through the step
      if (adv) begin
        state_q <= state_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

>>> rtl/u8d_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_checker
// port-level checks on the utf-8 stream decoder
// ----------------------------------------------------------------------------
module u8d_checker
  import u8d_pkg::*;
(
  input wire           clk_i,
  input wire           rst_ni,
  input wire           in_valid_i,
  input wire           in_stall_o,
  input wire u8d_in_t  in_data_i,
  input wire           out_valid_o,
  input wire           out_stall_i,
  input wire u8d_out_t out_data_o
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  // an accepted beat is followed, past the input register, by a valid result beat
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> ##1 out_valid_o)
    else $error("no result after accepted beat");

  // code point only carries a value with the code point status
  a_cp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_CODEPOINT |-> out_data_o.code_point == '0)
    else $error("code point set on a non code point beat");

  // decoded values stay within the unicode range, and status is a known code
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.code_point <= MAX_CODE_POINT &&
                    out_data_o.status <= ST_TRUNC)
    else $error("result beat out of range");

endmodule

bind utf8_stream_decoder u8d_checker u_u8d_checker (.*);
`default_nettype wire

>>> tb/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the utf-8 stream decoder: a short table of opening
// beats, then random byte streams made mostly of well-formed sequences; every
// accepted beat is decoded by a local predictor and each result beat is
// compared field by field against the oldest prediction
// ----------------------------------------------------------------------------
module tb_top;
  import u8d_pkg::*;

  // one planned input beat; fixed rows carry a hand-written result
  typedef struct packed {
    u8d_in_t  beat;
    logic     fixed;
    u8d_out_t want;
  } byte_plan_t;

  localparam int unsigned RANDOM_BEATS = 1550;
  localparam int unsigned QUIET_TAIL   = 200;   // last beats run with no idling
  localparam int unsigned DRAIN_CYCLES = 8;     // result passes the input, then the result register

  // opening stimulus: extremes, every error code and each resync path
  localparam byte_plan_t OPENING [28] = '{
    '{'{REQ_FINISH, 8'h00}, 1'b1, '{21'h0,      ST_CONSUMED}},  // finish from reset
    '{'{REQ_DATA,   8'h00}, 1'b1, '{21'h0,      ST_CODEPOINT}},
    '{'{REQ_DATA,   8'h7F}, 1'b1, '{21'h7F,     ST_CODEPOINT}},
    '{'{REQ_DATA,   8'h80}, 1'b1, '{21'h0,      ST_BADLEAD}},   // lone continuation
    '{'{REQ_DATA,   8'hBF}, 1'b1, '{21'h0,      ST_CONSUMED}},  // skipped in resync
    '{'{REQ_DATA,   8'hFF}, 1'b1, '{21'h0,      ST_BADLEAD}},
    '{'{REQ_DATA,   8'hFE}, 1'b1, '{21'h0,      ST_BADLEAD}},
    '{'{REQ_DATA,   8'hC3}, 1'b0, '0},                          // two-byte form
    '{'{REQ_DATA,   8'hA9}, 1'b0, '0},
    '{'{REQ_DATA,   8'hF4}, 1'b0, '0},                          // top of the range
    '{'{REQ_DATA,   8'h8F}, 1'b0, '0},
    '{'{REQ_DATA,   8'hBF}, 1'b0, '0},
    '{'{REQ_DATA,   8'hBF}, 1'b1, '{21'h10FFFF, ST_CODEPOINT}},
    '{'{REQ_DATA,   8'hF4}, 1'b0, '0},                          // one past the range
    '{'{REQ_DATA,   8'h90}, 1'b0, '0},
    '{'{REQ_DATA,   8'h80}, 1'b0, '0},
    '{'{REQ_DATA,   8'h80}, 1'b1, '{21'h0,      ST_RANGE}},
    '{'{REQ_DATA,   8'hFD}, 1'b0, '0},                          // six-byte, all ones
    '{'{REQ_DATA,   8'hBF}, 1'b0, '0},
    '{'{REQ_DATA,   8'hBF}, 1'b0, '0},
    '{'{REQ_DATA,   8'hBF}, 1'b0, '0},
    '{'{REQ_DATA,   8'hBF}, 1'b0, '0},
    '{'{REQ_DATA,   8'hBF}, 1'b1, '{21'h0,      ST_RANGE}},
    '{'{REQ_DATA,   8'hE2}, 1'b0, '0},                          // broken sequence
    '{'{REQ_DATA,   8'h41}, 1'b1, '{21'h0,      ST_BADCONT}},
    '{'{REQ_DATA,   8'h42}, 1'b0, '0},                          // leaves resync at once
    '{'{REQ_DATA,   8'hF8}, 1'b0, '0},                          // five-byte lead, then cut
    '{'{REQ_FINISH, 8'h00}, 1'b1, '{21'h0,      ST_TRUNC}}
  };

  logic     clk_i;
  logic     rst_ni    = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  u8d_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  u8d_out_t out_data;

  byte_plan_t  byte_plan [$];     // beats still to be sent
  u8d_out_t    decodes_due [$];   // predicted result beats, oldest first
  u8d_state_t  decoder;           // predictor copy of the decoder state
  byte_plan_t  in_flight;         // beat currently on the input channel
  int unsigned total_beats;
  int unsigned beats_taken = 0;
  int unsigned mismatches  = 0;

  // idling: each side rolls a mood now and then (0 means no bursts at all)
  int unsigned send_hold = 0, send_mood = 0, send_mood_left = 0;
  int unsigned recv_hold = 0, recv_mood = 0, recv_mood_left = 0;

  utf8_stream_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // predictor: advance the decoder state by one beat and return its result
  function automatic u8d_out_t decode_beat(u8d_in_t beat);
    u8d_out_t res;
    logic     cont;
    res  = '0;
    cont = (beat.data_byte[7:6] == 2'b10);
    if (beat.req_type == REQ_FINISH) begin
      // end of stream: a half-built sequence counts as truncated
      res.status = (decoder.mode == MODE_FOLLOW) ? ST_TRUNC : ST_CONSUMED;
      decoder    = STATE_RESET;
    end else if (decoder.mode == MODE_FOLLOW) begin
      if (!cont) begin
        // foreign byte inside a sequence is dropped
        decoder.mode = MODE_RESYNC;
        res.status   = ST_BADCONT;
      end else begin
        decoder.acc  = {decoder.acc[ACC_W-7:0], beat.data_byte[5:0]};
        decoder.seen = decoder.seen + 3'd1;
        if (decoder.seen != decoder.len) begin
          res.status = ST_CONSUMED;
        end else begin
          decoder.mode = MODE_START;
          if (decoder.acc > ACC_W'(MAX_CODE_POINT)) begin
            res.status = ST_RANGE;
          end else begin
            res.code_point = decoder.acc[CP_W-1:0];
            res.status     = ST_CODEPOINT;
          end
        end
      end
    end else if (decoder.mode == MODE_RESYNC && cont) begin
      res.status = ST_CONSUMED;
    end else begin
      // start mode, or the first non-continuation byte out of resync
      decoder.mode = MODE_START;
      res.status   = ST_CONSUMED;
      casez (beat.data_byte)
        8'b0???????: begin
          res.code_point = CP_W'(beat.data_byte);
          res.status     = ST_CODEPOINT;
        end
        8'b110?????: begin
          decoder.acc = ACC_W'(beat.data_byte[4:0]);
          decoder.len = 3'd2;
        end
        8'b1110????: begin
          decoder.acc = ACC_W'(beat.data_byte[3:0]);
          decoder.len = 3'd3;
        end
        8'b11110???: begin
          decoder.acc = ACC_W'(beat.data_byte[2:0]);
          decoder.len = 3'd4;
        end
        8'b111110??: begin
          decoder.acc = ACC_W'(beat.data_byte[1:0]);
          decoder.len = 3'd5;
        end
        8'b1111110?: begin
          decoder.acc = ACC_W'(beat.data_byte[0]);
          decoder.len = 3'd6;
        end
        default: begin
          decoder.mode = MODE_RESYNC;
          res.status   = ST_BADLEAD;
        end
      endcase
      // a lead byte that opened a sequence moves on to follow-on mode
      if (res.status == ST_CONSUMED) begin
        decoder.mode = MODE_FOLLOW;
        decoder.seen = 3'd1;
      end
    end
    return res;
  endfunction

  function automatic void schedule_byte(logic req, logic [7:0] b);
    byte_plan_t p;
    p          = '0;
    p.beat     = '{req, b};
    byte_plan.push_back(p);
  endfunction

  // one random run of bytes: mostly well-formed sequences, plus noise
  task automatic queue_random_run();
    int unsigned pick, n, cut;
    logic [7:0]  lead, odd;
    pick = $urandom_range(0, 99);
    n    = $urandom_range(2, 6);
    lead = ~(8'hFF >> n) | (8'($urandom) & (8'hFF >> (n + 1)));
    // bias some four-byte leads onto the edge of the code space
    if (n == 4 && $urandom_range(0, 3) == 0) begin
      lead = 8'hF4;
    end
    odd = 8'($urandom);
    if (odd[7:6] == 2'b10) begin
      odd[6] = 1'b1;
    end
    if (pick < 30) begin
      schedule_byte(REQ_DATA, 8'($urandom_range(0, 127)));
    end else if (pick < 80) begin
      schedule_byte(REQ_DATA, lead);
      repeat (n - 1) schedule_byte(REQ_DATA, {2'b10, 6'($urandom)});
    end else if (pick < 88) begin
      // sequence cut short by a foreign byte or by end of stream
      cut = $urandom_range(0, n - 2);
      schedule_byte(REQ_DATA, lead);
      repeat (cut) schedule_byte(REQ_DATA, {2'b10, 6'($urandom)});
      if ($urandom_range(0, 2) == 0) begin
        schedule_byte(REQ_FINISH, 8'($urandom));
      end else begin
        schedule_byte(REQ_DATA, odd);
      end
    end else if (pick < 90) begin
      schedule_byte(REQ_DATA, 8'($urandom));
    end else if (pick < 95) begin
      schedule_byte(REQ_FINISH, 8'($urandom));
    end else begin
      // bad lead followed by stray continuation bytes
      if ($urandom_range(0, 1) == 0) begin
        schedule_byte(REQ_DATA, {2'b10, 6'($urandom)});
      end else begin
        schedule_byte(REQ_DATA, {7'h7F, 1'($urandom)});
      end
      repeat ($urandom_range(0, 4)) schedule_byte(REQ_DATA, {2'b10, 6'($urandom)});
    end
  endtask

  // start an idle burst? never in the quiet tail of the run
  function automatic bit burst_due(int unsigned mood);
    return mood != 0 && byte_plan.size() > QUIET_TAIL &&
           $urandom_range(0, mood * 6) == 0;
  endfunction

  task automatic flag_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  // input side: present planned beats, predict each one as it is taken
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        if (in_flight.fixed) begin
          void'(decode_beat(in_flight.beat));
          decodes_due.push_back(in_flight.want);
        end else begin
          decodes_due.push_back(decode_beat(in_flight.beat));
        end
        beats_taken++;
      end
      // payload may only move once the current beat is gone
      if (!in_valid || !in_stall) begin
        if (send_mood_left == 0) begin
          send_mood      = $urandom_range(0, 3);
          send_mood_left = $urandom_range(20, 120);
        end else begin
          send_mood_left--;
        end
        if (send_hold != 0) begin
          send_hold--;
          in_valid <= 1'b0;
        end else if (byte_plan.size() != 0 && burst_due(send_mood)) begin
          send_hold = $urandom_range(0, 18);
          in_valid <= 1'b0;
        end else if (byte_plan.size() != 0) begin
          in_flight = byte_plan.pop_front();
          in_valid <= 1'b1;
          in_data  <= in_flight.beat;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output side: check each result beat, stall in random bursts
  always @(posedge clk_i) begin
    u8d_out_t want;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (decodes_due.size() == 0) begin
          flag_mismatch($sformatf("result beat %0h/%0d with nothing outstanding",
                                  out_data.code_point, out_data.status));
        end else begin
          want = decodes_due.pop_front();
          if (out_data.status !== want.status) begin
            flag_mismatch($sformatf("status expected %0d got %0d",
                                    want.status, out_data.status));
          end else if (out_data.code_point !== want.code_point) begin
            flag_mismatch($sformatf("code_point expected %06h got %06h",
                                    want.code_point, out_data.code_point));
          end
        end
      end
      if (recv_mood_left == 0) begin
        recv_mood      = $urandom_range(0, 3);
        recv_mood_left = $urandom_range(20, 120);
      end else begin
        recv_mood_left--;
      end
      if (recv_hold != 0) begin
        recv_hold--;
        out_stall <= 1'b1;
      end else if (burst_due(recv_mood)) begin
        recv_hold = $urandom_range(0, 18);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // main sequence: build the whole stream, release reset, wait for the drain
  initial begin
    decoder = STATE_RESET;
    foreach (OPENING[i]) byte_plan.push_back(OPENING[i]);
    while (byte_plan.size() < $size(OPENING) + RANDOM_BEATS) queue_random_run();
    total_beats = byte_plan.size();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (beats_taken != total_beats) @(posedge clk_i);
    while (decodes_due.size() != 0) @(posedge clk_i);
    // let any stray result beat turn up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

endmodule
`default_nettype wire

>>> filelist.f
rtl/u8d_pkg.sv
rtl/u8d_step.sv
rtl/utf8_stream_decoder.sv
rtl/u8d_checker.sv
tb/tb_top.sv
